>>> src/battery_level_percent_estimator_macros.svh
// Assertion macros for the battery level percent estimator.
`ifndef BATTERY_LEVEL_PERCENT_ESTIMATOR_MACROS_SVH
`define BATTERY_LEVEL_PERCENT_ESTIMATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define BLPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define BLPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/blpe_pkg.sv
// Shared types, constants and microcode for the battery level percent estimator.
package blpe_pkg;

  localparam int SAMPLE_BITS_DEF = 13;
  localparam int CFG_W           = 16;
  localparam int RATIO_W         = 4;
  localparam int PERIOD_W        = 4;
  localparam int PCT_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int PC_W            = 4;

  localparam logic [PCT_W-1:0]    PCT_MAX    = 7'd100;
  localparam logic [CFG_W-1:0]    FULL_RST   = 16'd6000;
  localparam logic [CFG_W-1:0]    EMPTY_RST  = 16'd4800;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 4'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 4'd8;

  localparam logic CMD_PRIME = 1'b0;

  // floor(x/100) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2^17
  localparam int               RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP     = 18'd167773;
  localparam int               RECIP_SHIFT = 24;

  // Percent divide: quotient < 128, dividend < span * 2^7
  localparam int DIV_STEPS = 7;
  localparam int DIV_CNT_W = 3;
  localparam int REM_W     = CFG_W + DIV_STEPS;
  localparam int DSH_W     = CFG_W + DIV_STEPS - 1;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_PRIME,
    OP_COUNT,
    OP_STEP_MUL,
    OP_BAND_MUL,
    OP_LIMIT,
    OP_VMUL,
    OP_CLASS,
    OP_DIV,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_PRIME,
    C_NO_SAMPLE,
    C_SATURATE,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic is_prime;
    logic no_sample;
    logic saturate;
    logic div_more;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    logic [CFG_W-1:0]    full_mv;
    logic [CFG_W-1:0]    empty_mv;
    logic [RATIO_W-1:0]  divider_ratio;
    logic [PERIOD_W-1:0] sample_period;
  } cfg_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_COUNT    = 4'd2;
  localparam logic [PC_W-1:0] PC_STEP_MUL = 4'd3;
  localparam logic [PC_W-1:0] PC_BAND_MUL = 4'd4;
  localparam logic [PC_W-1:0] PC_LIMIT    = 4'd5;
  localparam logic [PC_W-1:0] PC_VMUL     = 4'd6;
  localparam logic [PC_W-1:0] PC_CLASS    = 4'd7;
  localparam logic [PC_W-1:0] PC_DIV      = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd9;
  localparam logic [PC_W-1:0] PC_PRIME    = 4'd10;

  // Control store: jump to target when cond holds, else fall through.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:     w = '{OP_ACCEPT,   C_NONE,      PC_IDLE};
      PC_DISPATCH: w = '{OP_NOP,      C_PRIME,     PC_PRIME};
      PC_COUNT:    w = '{OP_COUNT,    C_NO_SAMPLE, PC_VMUL};
      PC_STEP_MUL: w = '{OP_STEP_MUL, C_NONE,      PC_IDLE};
      PC_BAND_MUL: w = '{OP_BAND_MUL, C_NONE,      PC_IDLE};
      PC_LIMIT:    w = '{OP_LIMIT,    C_NONE,      PC_IDLE};
      PC_VMUL:     w = '{OP_VMUL,     C_NONE,      PC_IDLE};
      PC_CLASS:    w = '{OP_CLASS,    C_SATURATE,  PC_EMIT};
      PC_DIV:      w = '{OP_DIV,      C_DIV_MORE,  PC_DIV};
      PC_EMIT:     w = '{OP_EMIT,     C_ALWAYS,    PC_IDLE};
      PC_PRIME:    w = '{OP_PRIME,    C_ALWAYS,    PC_IDLE};
      default:     w = '{OP_NOP,      C_ALWAYS,    PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> src/blpe_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
module blpe_seq
  import blpe_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            stall;
  logic            take;

  assign ctrl = ucode(pc);

  // Hold on the wait steps: no item offered, or result slot still full.
  assign stall = ((ctrl.op == OP_ACCEPT) && !in_valid) ||
                 ((ctrl.op == OP_EMIT) && flags.out_busy);

  always_comb begin
    case (ctrl.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_PRIME:     take = flags.is_prime;
      C_NO_SAMPLE: take = flags.no_sample;
      C_SATURATE:  take = flags.saturate;
      C_DIV_MORE:  take = flags.div_more;
      default:     take = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> src/blpe_dpath.sv
// Datapath: history, filter, tick counter, step limiter, percent divider, output register.
module blpe_dpath
  import blpe_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_t                  ctrl,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  input  logic                   sample_ok,
  input  logic                   out_ready,
  output flags_t                 flags,
  output logic                   out_valid,
  output logic [PCT_W-1:0]       percent
);

  localparam int SB   = SAMPLE_BITS;
  localparam int P_W  = SB + 1 + RECIP_W;
  localparam int PR_W = SB + RATIO_W;
  localparam int V_W  = ((PR_W > CFG_W) ? PR_W : CFG_W) + 1;

  logic                 cmd_q;
  logic [SB-1:0]        smp_q;
  logic                 ok_q;
  logic [SB-1:0]        hist0;
  logic [SB-1:0]        hist1;
  logic [SB-1:0]        hist2;
  logic [SB-1:0]        filt;
  logic [PERIOD_W-1:0]  tick;
  logic [SB-1:0]        rd;
  logic [SB-1:0]        step;
  logic [P_W-1:0]       prod;
  logic signed [V_W-1:0] v;
  logic [REM_W-1:0]     rem;
  logic [DSH_W-1:0]     dsh;
  logic [PCT_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [PERIOD_W:0]    cnt;
  logic                 sample;
  logic [SB-1:0]        band;
  logic [SB:0]          up;
  logic [SB-1:0]        lim;
  logic [SB-1:0]        pick;
  logic [PR_W-1:0]      scaled;
  logic signed [V_W-1:0] v_next;
  logic signed [CFG_W:0] span;
  logic signed [V_W-1:0] span_ext;
  logic                 v_low;
  logic                 sat;
  logic                 ge;
  logic                 out_busy;
  logic                 emit;

  function automatic logic [SB-1:0] sample_ok_sel(input logic ok, input logic [SB-1:0] s,
                                                  input logic [SB-1:0] f);
    return ok ? s : f;
  endfunction

  always_comb begin
    cnt    = {1'b0, tick} + (PERIOD_W+1)'(1);
    sample = cnt > {1'b0, cfg.sample_period};
    pick   = sample_ok_sel(ok_q, smp_q, filt);

    band = SB'(prod >> RECIP_SHIFT);
    up   = {1'b0, hist2} + {1'b0, step};
    if (hist2 > rd) begin
      lim = ((hist2 - rd) > band) ? (hist2 - step) : rd;
    end else if ((rd - hist2) > band) begin
      lim = up[SB] ? {SB{1'b1}} : up[SB-1:0];
    end else begin
      lim = rd;
    end

    scaled   = PR_W'(filt) * PR_W'(cfg.divider_ratio);
    v_next   = $signed(V_W'(scaled)) - $signed(V_W'(cfg.empty_mv));
    span     = $signed({1'b0, cfg.full_mv}) - $signed({1'b0, cfg.empty_mv});
    span_ext = V_W'(span);
    v_low    = (v <= 0);
    sat      = v_low || (span <= 0) || (v >= span_ext);

    ge = rem >= REM_W'(dsh);

    out_busy = out_valid && !out_ready;
    emit     = (ctrl.op == OP_EMIT) && !out_busy;
  end

  assign flags.is_prime  = (cmd_q == CMD_PRIME);
  assign flags.no_sample = !sample;
  assign flags.saturate  = sat;
  assign flags.div_more  = (div_cnt != '0);
  assign flags.out_busy  = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist0     <= '0;
      hist1     <= '0;
      hist2     <= '0;
      filt      <= '0;
      tick      <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        percent   <= quo;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_ACCEPT: begin
          if (in_valid) begin
            cmd_q <= cmd;
            smp_q <= sample_mv;
            ok_q  <= sample_ok;
          end
        end
        OP_PRIME: begin
          filt  <= pick;
          hist0 <= pick;
          hist1 <= pick;
          hist2 <= pick;
        end
        OP_COUNT: begin
          tick <= sample ? '0 : cnt[PERIOD_W-1:0];
        end
        OP_STEP_MUL: begin
          rd   <= pick;
          prod <= P_W'(hist2) * P_W'(RECIP);
        end
        OP_BAND_MUL: begin
          step <= SB'(prod >> RECIP_SHIFT);
          prod <= P_W'({hist2, 1'b0}) * P_W'(RECIP);
        end
        OP_LIMIT: begin
          hist0 <= hist1;
          hist1 <= hist2;
          hist2 <= lim;
          filt  <= SB'(({1'b0, hist2} + {1'b0, hist1}) >> 1);
        end
        OP_VMUL: begin
          v <= v_next;
        end
        OP_CLASS: begin
          if (sat) begin
            quo <= v_low ? '0 : PCT_MAX;
          end else begin
            quo     <= '0;
            rem     <= REM_W'(v[CFG_W-1:0]) * REM_W'(PCT_MAX);
            dsh     <= DSH_W'(span[CFG_W-1:0]) << (DIV_STEPS - 1);
            div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
          end
        end
        OP_DIV: begin
          // One quotient bit per step, restoring.
          if (ge) begin
            rem <= rem - REM_W'(dsh);
          end
          quo     <= {quo[PCT_W-2:0], ge};
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/battery_level_percent_estimator.sv
// Top level of the battery level percent estimator: config registers, sequencer, datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): cmd, sample_mv, sample_ok. cmd 0 primes the
//   history and filtered value and gives no result; cmd 1 is a periodic tick that
//   gives one percent item on the output channel (out_valid/out_ready).
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write it only while the block is idle.
//   A prime runs only its prime step. A tick that takes a sample runs the step
//   and band multiplies and the limit step before the voltage multiply; each
//   tick then classifies and, unless saturated at 0 or 100 percent, runs the
//   seven-step restoring divide loop, the longest path, before its emit step.
//   One item is in work at a time; the next is accepted only after it finishes.
//   Reset clears history, filtered value, tick count and the output valid flag,
//   and loads the default thresholds, ratio and period.
//   A stalled receiver holds the result in the output register; the block may
//   take and work one more item, then waits at its emit step until the slot frees.
module battery_level_percent_estimator
  import blpe_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample_mv,
  input  logic                   sample_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PCT_W-1:0]       percent,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

`include "battery_level_percent_estimator_macros.svh"

  cfg_t   cfg;
  ctrl_t  ctrl;
  flags_t flags;

  assign cfg_ready = 1'b1;
  assign in_ready  = (ctrl.op == OP_ACCEPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.full_mv       <= FULL_RST;
      cfg.empty_mv      <= EMPTY_RST;
      cfg.divider_ratio <= RATIO_RST;
      cfg.sample_period <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FULL_MV:       cfg.full_mv       <= cfg_data;
        REG_EMPTY_MV:      cfg.empty_mv      <= cfg_data;
        REG_DIVIDER_RATIO: cfg.divider_ratio <= cfg_data[RATIO_W-1:0];
        REG_SAMPLE_PERIOD: cfg.sample_period <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  blpe_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  blpe_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .sample_mv (sample_mv),
    .sample_ok (sample_ok),
    .out_ready (out_ready),
    .flags     (flags),
    .out_valid (out_valid),
    .percent   (percent)
  );

  `BLPE_ASSERT_NOW(a_pct_range, out_valid, percent <= PCT_MAX, "percent above 100")
  `BLPE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
  `BLPE_ASSERT_NOW(a_emit_not_idle, $rose(out_valid), !$past(in_ready), "result without work")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the battery level percent estimator.
module testbench;
  import blpe_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SB) - 1;
  localparam logic CMD_TICK = ~CMD_PRIME;
  localparam int SETTLE_CYCLES = 32;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 32;

  typedef struct packed {
    logic          c;
    logic [SB-1:0] mv;
    logic          ok;
  } batt_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = CMD_PRIME;
  logic [SB-1:0]        sample_mv = '0;
  logic                 sample_ok = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PCT_W-1:0]     percent;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  battery_level_percent_estimator #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .sample_mv(sample_mv), .sample_ok(sample_ok),
    .out_valid(out_valid), .out_ready(out_ready), .percent(percent),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state and its copy of the registers
  logic [CFG_W-1:0]    m_full   = FULL_RST;
  logic [CFG_W-1:0]    m_empty  = EMPTY_RST;
  logic [RATIO_W-1:0]  m_ratio  = RATIO_RST;
  logic [PERIOD_W-1:0] m_period = PERIOD_RST;
  logic [SB-1:0]       m_hist [3] = '{default: '0};
  logic [SB-1:0]       m_filt  = '0;
  logic [PERIOD_W-1:0] m_ticks = '0;

  batt_item_t       pending_items [$];
  logic [PCT_W-1:0] pct_expected [$];

  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int n_primes = 0;
  int n_samples = 0;
  int n_zero = 0;
  int n_full = 0;
  int errors = 0;
  int in_gap = 0;
  int out_hold = 0;
  int stall_cycles = 0;
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;
  batt_item_t       next_item;
  logic [PCT_W-1:0] pct_want;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Advances the battery state by one item and queues the percent a tick reports.
  function automatic void battery_step(input logic c, input logic [SB-1:0] mv,
                                       input logic ok);
    int unsigned nxt_count, rd, h, band, stp, sum;
    longint v, span;
    logic [PCT_W-1:0] p;
    if (c == CMD_PRIME) begin
      if (ok) m_filt = mv;
      m_hist[0] = m_filt;
      m_hist[1] = m_filt;
      m_hist[2] = m_filt;
      n_primes++;
      return;
    end
    nxt_count = 32'(m_ticks) + 1;
    if (nxt_count > m_period) begin
      m_ticks = '0;
      rd = ok ? 32'(mv) : 32'(m_filt);
      h = 32'(m_hist[2]);
      band = (h * 2) / 100;
      stp = h / 100;
      // limit a jump past two percent of the newest entry to a one-percent step
      if (h > rd && h - rd > band) rd = h - stp;
      else if (rd > h && rd - h > band) rd = (h + stp > SAMPLE_MAX) ? SAMPLE_MAX : h + stp;
      sum = 32'(m_hist[2]);
      sum += 32'(m_hist[1]);
      m_filt = SB'(sum >> 1);
      m_hist[0] = m_hist[1];
      m_hist[1] = m_hist[2];
      m_hist[2] = SB'(rd);
      n_samples++;
    end else begin
      m_ticks = PERIOD_W'(nxt_count);
    end
    v = longint'(m_filt) * longint'(m_ratio) - longint'(m_empty);
    span = longint'(m_full) - longint'(m_empty);
    if (v <= 0) p = '0;
    else if (span <= 0 || v >= span) p = PCT_MAX;
    else p = PCT_W'((v * 100) / span);
    if (p == 0) n_zero++;
    if (p == PCT_MAX) n_full++;
    pct_expected.push_back(p);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        battery_step(cmd, sample_mv, sample_ok);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          cmd <= next_item.c;
          sample_mv <= next_item.mv;
          sample_ok <= next_item.ok;
          in_valid <= 1'b1;
          in_gap = in_gaps_on ? $urandom_range(0, 16) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pct_expected.size() == 0) begin
          report_mismatch("unexpected percent item", int'(percent), -1);
        end else begin
          pct_want = pct_expected.pop_front();
          if (percent !== pct_want) report_mismatch("percent", int'(percent), int'(pct_want));
          results_checked++;
        end
        out_hold = out_stalls_on ? $urandom_range(0, 16) : 0;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FULL_MV:       m_full = val[CFG_W-1:0];
      REG_EMPTY_MV:      m_empty = val[CFG_W-1:0];
      REG_DIVIDER_RATIO: m_ratio = val[RATIO_W-1:0];
      REG_SAMPLE_PERIOD: m_period = val[PERIOD_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(input int unsigned full_v, input int unsigned empty_v,
                            input int unsigned ratio_v, input int unsigned period_v);
    write_reg(REG_FULL_MV, full_v);
    write_reg(REG_EMPTY_MV, empty_v);
    write_reg(REG_DIVIDER_RATIO, ratio_v);
    write_reg(REG_SAMPLE_PERIOD, period_v);
  endtask

  task automatic queue_item(input logic c, input int mv, input logic ok);
    batt_item_t it;
    it.c = c;
    it.mv = mv[SB-1:0];
    it.ok = ok;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // waits until every item is taken and every percent checked, then lets a prime finish
  task automatic drain;
    while (items_accepted != items_queued || pct_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a random register setting, a prime, then a slowly discharging battery
  task automatic discharge_run(input int n_items);
    int unsigned full_v, empty_v, ratio_v, period_v, roll;
    int lvl, mv, jit, k;
    roll = $urandom_range(0, 9);
    if (roll < 8) begin
      empty_v = $urandom_range(0, 40000);
      full_v = empty_v + $urandom_range(50, 20000);
    end else if (roll == 8) begin
      full_v = $urandom_range(0, 65535);
      empty_v = $urandom_range(full_v, 65535);
    end else begin
      full_v = $urandom_range(0, 1) * 65535;
      empty_v = $urandom_range(0, 1) * 65535;
    end
    roll = $urandom_range(0, 19);
    ratio_v = (roll < 17) ? $urandom_range(1, 8) : (roll == 17) ? 0 : $urandom_range(9, 15);
    roll = $urandom_range(0, 9);
    period_v = (roll < 6) ? $urandom_range(0, 2) : (roll < 9) ? $urandom_range(3, 14) : 15;
    in_gaps_on = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
    set_config(full_v, empty_v, ratio_v, period_v);

    if (ratio_v == 0 || full_v <= empty_v) lvl = $urandom_range(0, SAMPLE_MAX);
    else lvl = (empty_v + $urandom_range(0, full_v - empty_v)) / ratio_v;
    if (lvl > SAMPLE_MAX) lvl = SAMPLE_MAX;

    queue_item(CMD_PRIME, lvl, 1'b1);
    for (k = 1; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      jit = lvl / 60 + 2;
      if (roll < 6) begin
        queue_item(CMD_PRIME, lvl, $urandom_range(0, 3) != 0);
      end else begin
        if (roll < 14) begin
          mv = $urandom_range(0, SAMPLE_MAX);
        end else if (roll < 26) begin
          // a jump of one to six jitter widths, either way
          mv = $urandom_range(jit, 6 * jit);
          mv = $urandom_range(0, 1) ? lvl + mv : lvl - mv;
        end else begin
          mv = lvl + int'($urandom_range(0, 2 * jit)) - jit;
        end
        if (mv < 0) mv = 0;
        if (mv > SAMPLE_MAX) mv = SAMPLE_MAX;
        queue_item(CMD_TICK, mv, $urandom_range(0, 7) != 0);
      end
      lvl -= $urandom_range(0, lvl / 400 + 1);
      if (lvl < 0) lvl = 0;
    end
    drain();
  endtask

  initial begin
    int ph;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty state, failed prime, prime, tick that does not sample
    queue_item(CMD_TICK, 0, 1'b1);
    queue_item(CMD_PRIME, SAMPLE_MAX, 1'b0);
    queue_item(CMD_PRIME, 1800, 1'b1);
    queue_item(CMD_TICK, 1800, 1'b1);
    drain();

    // sample every tick: in band, step up, failed reading, step down
    set_config(6000, 4800, 3, 0);
    queue_item(CMD_TICK, 1810, 1'b1);
    queue_item(CMD_TICK, SAMPLE_MAX, 1'b1);
    queue_item(CMD_TICK, 0, 1'b0);
    queue_item(CMD_TICK, 0, 1'b1);
    drain();

    // widest span, top ratio, longest period
    set_config(65535, 0, 15, 15);
    queue_item(CMD_PRIME, SAMPLE_MAX, 1'b1);
    queue_item(CMD_TICK, SAMPLE_MAX, 1'b0);
    drain();

    // span below zero
    set_config(0, 65535, 15, 0);
    queue_item(CMD_PRIME, SAMPLE_MAX, 1'b1);
    queue_item(CMD_TICK, SAMPLE_MAX, 1'b1);
    queue_item(CMD_TICK, 100, 1'b1);
    drain();

    // ratio zero
    set_config(6000, 0, 0, 0);
    queue_item(CMD_PRIME, 5000, 1'b1);
    queue_item(CMD_TICK, 5000, 1'b1);
    drain();

    // unity ratio, mid-range percentages, sample every other tick
    set_config(8191, 0, 1, 1);
    queue_item(CMD_PRIME, 4000, 1'b1);
    queue_item(CMD_TICK, 4000, 1'b1);
    queue_item(CMD_TICK, 4060, 1'b1);
    queue_item(CMD_TICK, 3900, 1'b1);
    queue_item(CMD_TICK, 2000, 1'b0);
    queue_item(CMD_TICK, 4100, 1'b1);
    queue_item(CMD_TICK, 4100, 1'b1);
    drain();

    for (ph = 0; ph < RANDOM_PHASES; ph++) discharge_run(PHASE_ITEMS);

    $display("Run covered %0d items (%0d primes, %0d sampling ticks), %0d register writes",
             items_accepted, n_primes, n_samples, cfg_writes);
    $display("Checked %0d percent results: %0d at zero, %0d at full, %0d in between",
             results_checked, n_zero, n_full, results_checked - n_zero - n_full);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/blpe_pkg.sv
src/blpe_seq.sv
src/blpe_dpath.sv
src/battery_level_percent_estimator.sv
tb/testbench.sv
